@@ src/xopc_pkg.sv @@
// Package for the x86 opcode pattern counter: sizes, operation codes,
// counter indexes, queue entry type and the pattern classifier function.
// No dependencies.
package xopc_pkg;

  localparam int WindowBytes  = 10;
  localparam int CounterBits  = 48;
  localparam int NumCounters  = 20;
  localparam int CntIdxBits   = 5;
  localparam int FillBits     = 4;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [4:0] C_BYTES    = 5'd0;
  localparam logic [4:0] C_PUSH     = 5'd1;
  localparam logic [4:0] C_POP      = 5'd2;
  localparam logic [4:0] C_CALL     = 5'd3;
  localparam logic [4:0] C_ICALL    = 5'd4;
  localparam logic [4:0] C_RET      = 5'd5;
  localparam logic [4:0] C_LEAVE    = 5'd6;
  localparam logic [4:0] C_JCC      = 5'd7;
  localparam logic [4:0] C_JMP      = 5'd8;
  localparam logic [4:0] C_SETCC    = 5'd9;
  localparam logic [4:0] C_MOVSXD   = 5'd10;
  localparam logic [4:0] C_SYSCALL  = 5'd11;
  localparam logic [4:0] C_PROLOGUE = 5'd12;
  localparam logic [4:0] C_SSUB     = 5'd13;
  localparam logic [4:0] C_SADD     = 5'd14;
  localparam logic [4:0] C_SLOAD    = 5'd15;
  localparam logic [4:0] C_SSTORE   = 5'd16;
  localparam logic [4:0] C_XORZ     = 5'd17;
  localparam logic [4:0] C_MOVZ     = 5'd18;
  localparam logic [4:0] C_LEA      = 5'd19;

  typedef logic [7:0] byte_t;
  typedef byte_t [WindowBytes-1:0] win_t;

  // Command handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_BUMP  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic            hit;   // bump: pattern counter valid
    logic [4:0]      idx;   // pattern counter or read select
    logic            tot;   // bump: also count one byte
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
    logic [3:0] skip;
  } cls_t;

  function automatic logic is_rex(input byte_t b);
    return b[7:4] == 4'h4;
  endfunction

  function automatic logic reg_self(input byte_t m);
    return m[7:6] == 2'b11 && m[5:3] == m[2:0];
  endfunction

  function automatic cls_t mk(input logic [4:0] idx, input int unsigned s);
    cls_t r;
    r.hit  = 1'b1;
    r.idx  = idx;
    r.skip = s[3:0];
    return r;
  endfunction

  // Test one position: p[0] first byte, m bytes visible (1..WindowBytes).
  function automatic cls_t classify(input win_t p, input logic [FillBits-1:0] m);
    cls_t r;
    byte_t b0, b1, b2, op, modrm;
    int unsigned j, len, mi, disp;
    logic z, ld, st;
    r = '0;
    mi = int'(m);
    b0 = p[0];
    b1 = (mi > 1) ? p[1] : 8'h00;
    b2 = (mi > 2) ? p[2] : 8'h00;
    j = is_rex(b0) ? 1 : 0;
    op = p[j];
    modrm = p[j+1];
    ld = (op == 8'h8A || op == 8'h8B);
    st = (op == 8'h88 || op == 8'h89);
    disp = (modrm[7:6] == 2'd1) ? 1 : ((modrm[7:6] == 2'd2) ? 4 : 0);
    len = b0[3] ? 8 : 4;
    z = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (k < len && p[2+k] != 8'h00) z = 1'b0;
    end
    if (mi > 3 && b0 == 8'h55 && b1 == 8'h48 && b2 == 8'h89 && p[3] == 8'hE5)
      r = mk(C_PROLOGUE, 3);
    else if (b0 == 8'h0F && mi > 1 && b1 == 8'h05) r = mk(C_SYSCALL, 1);
    else if (b0 == 8'hC9) r = mk(C_LEAVE, 0);
    else if (mi > 3 && b0 == 8'h48 && b1 == 8'h83 && b2 == 8'hEC) r = mk(C_SSUB, 3);
    else if (mi > 6 && b0 == 8'h48 && b1 == 8'h81 && b2 == 8'hEC) r = mk(C_SSUB, 6);
    else if (mi > 3 && b0 == 8'h48 && b1 == 8'h83 && b2 == 8'hC4) r = mk(C_SADD, 3);
    else if (mi > 6 && b0 == 8'h48 && b1 == 8'h81 && b2 == 8'hC4) r = mk(C_SADD, 6);
    else if (b0 == 8'hFF && mi > 1 && b1[5:3] == 3'd2) r = mk(C_ICALL, 1);
    else if (b0 == 8'h8D) r = mk(C_LEA, 0);
    else if (is_rex(b0) && mi > 1 && b1 == 8'h8D) r = mk(C_LEA, 1);
    else if ((b0 == 8'h31 || b0 == 8'h33) && mi > 1 && reg_self(b1)) r = mk(C_XORZ, 1);
    else if (is_rex(b0) && mi > 2 && (b1 == 8'h31 || b1 == 8'h33) && reg_self(b2))
      r = mk(C_XORZ, 2);
    else if (b0 >= 8'hB8 && b0 <= 8'hBF && mi > 4 && p[1] == 0 && p[2] == 0 &&
             p[3] == 0 && p[4] == 0)
      r = mk(C_MOVZ, 4);
    else if (is_rex(b0) && mi > 1 && b1 >= 8'hB8 && b1 <= 8'hBF && 1 + len < mi && z)
      r = mk(C_MOVZ, 1 + len);
    else if ((ld || st) && j + 2 < mi && modrm[7:6] != 2'd3 && modrm[2:0] == 3'd4 &&
             p[j+2][2:0] == 3'd4)
      r = mk(ld ? C_SLOAD : C_SSTORE, j + 2 + disp);
    else if (b0 == 8'h41 && mi > 1 && b1 >= 8'h50 && b1 <= 8'h57) r = mk(C_PUSH, 1);
    else if (b0 == 8'h41 && mi > 1 && b1 >= 8'h58 && b1 <= 8'h5F) r = mk(C_POP, 1);
    else if (b0 >= 8'h48 && b0 <= 8'h4F && mi > 1 && b1 == 8'h63) r = mk(C_MOVSXD, 1);
    else if (is_rex(b0) && mi > 2 && b1 == 8'h0F && b2[7:4] == 4'h9) r = mk(C_SETCC, 2);
    else if (b0 == 8'h0F && mi > 1 && b1[7:4] == 4'h9) r = mk(C_SETCC, 1);
    else if (b0 == 8'h0F && mi > 1 && b1[7:4] == 4'h8) r = mk(C_JCC, mi > 5 ? 5 : 0);
    else if (b0 >= 8'h70 && b0 <= 8'h7F) r = mk(C_JCC, mi > 1 ? 1 : 0);
    else if (b0 == 8'hE8) r = mk(C_CALL, mi > 4 ? 4 : 0);
    else if (b0 == 8'hE9) r = mk(C_JMP, mi > 4 ? 4 : 0);
    else if (b0 == 8'hEB) r = mk(C_JMP, mi > 1 ? 1 : 0);
    else if (b0 == 8'hC3) r = mk(C_RET, 0);
    else if (b0 == 8'hC2) r = mk(C_RET, mi > 2 ? 2 : 0);
    else if (b0 >= 8'h50 && b0 <= 8'h57) r = mk(C_PUSH, 0);
    else if (b0 >= 8'h58 && b0 <= 8'h5F) r = mk(C_POP, 0);
    else if (b0 == 8'h63) r = mk(C_MOVSXD, 0);
    return r;
  endfunction

endpackage

@@ src/xopc_front.sv @@
// Front end: look-ahead window, skip tracking, section flush, classifier.
// Emits at most one command per cycle into the queue, stalling while the queue is full. Depends on xopc_pkg.
module xopc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           opcode_i,
  input  logic [7:0]           code_byte_i,
  input  logic                 section_end_i,
  input  logic [4:0]           counter_select_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output xopc_pkg::cmd_t       cmd_o
);
  import xopc_pkg::*;

  win_t                win_q, win_d;
  logic [FillBits-1:0] fill_q, fill_d;
  logic [3:0]          skip_q, skip_d;
  logic                flush_q, flush_d;
  logic [FillBits-1:0] pos_q, pos_d;

  win_t                win_in;
  logic [FillBits-1:0] fill_in;
  win_t                tpos;
  logic [FillBits-1:0] m;
  cls_t                cls;
  logic                acc, visit;
  op_e                 op;

  assign op = op_e'(opcode_i);
  assign in_ready_o = !flush_q && cmd_ready_i;
  assign acc = in_valid_i && in_ready_o;

  // Window after inserting the byte (used in the same cycle on a full window).
  always_comb begin
    win_in  = win_q;
    fill_in = fill_q;
    if (fill_q < FillBits'(WindowBytes)) begin
      win_in[fill_q] = code_byte_i;
      fill_in = fill_q + 1'b1;
    end
  end

  // Position under test: the window head, or the flush position.
  always_comb begin
    tpos = '0;
    for (int k = 0; k < WindowBytes; k++) begin
      if (flush_q) begin
        if (k + int'(pos_q) < WindowBytes) tpos[k] = win_q[k + int'(pos_q)];
      end else begin
        tpos[k] = win_in[k];
      end
    end
    m = flush_q ? fill_q - pos_q : fill_in;
  end

  assign cls = classify(tpos, m);

  always_comb begin
    win_d = win_q; fill_d = fill_q; skip_d = skip_q;
    flush_d = flush_q; pos_d = pos_q;
    visit = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_o = '0;
    if (flush_q) begin
      if (cmd_ready_i) begin
        visit = 1'b1;
        if (pos_q + 1'b1 >= fill_q) begin
          flush_d = 1'b0; win_d = '0; fill_d = '0; skip_d = '0; pos_d = '0;
          visit = 1'b0;
          cmd_valid_o = 1'b1;
          cmd_o.cmd = CMD_BUMP;
          cmd_o.hit = (skip_q == 0) && cls.hit;
          cmd_o.idx = cls.idx;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end else if (acc) begin
      unique case (op)
        OP_READ: begin
          cmd_valid_o = 1'b1;
          cmd_o.cmd = CMD_READ;
          cmd_o.idx = counter_select_i;
        end
        OP_CLEAR: begin
          cmd_valid_o = 1'b1;
          cmd_o.cmd = CMD_CLEAR;
        end
        OP_BYTE: begin
          cmd_valid_o = 1'b1;
          cmd_o.cmd = CMD_BUMP;
          cmd_o.tot = 1'b1;
          win_d = win_in; fill_d = fill_in;
          if (section_end_i) begin
            flush_d = 1'b1; pos_d = '0;
          end else if (fill_in >= FillBits'(WindowBytes)) begin
            cmd_o.hit = (skip_q == 0) && cls.hit;
            cmd_o.idx = cls.idx;
            skip_d = (skip_q != 0) ? skip_q - 1'b1 : cls.skip;
            for (int k = 0; k < WindowBytes - 1; k++) win_d[k] = win_in[k+1];
            win_d[WindowBytes-1] = '0;
            fill_d = fill_in - 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (visit) begin
      cmd_valid_o = (skip_q == 0) && cls.hit;
      cmd_o.cmd = CMD_BUMP;
      cmd_o.hit = 1'b1;
      cmd_o.idx = cls.idx;
      skip_d = (skip_q != 0) ? skip_q - 1'b1 : cls.skip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0; fill_q <= '0; skip_q <= '0; flush_q <= 1'b0; pos_q <= '0;
    end else begin
      win_q <= win_d; fill_q <= fill_d; skip_q <= skip_d;
      flush_q <= flush_d; pos_q <= pos_d;
    end
  end
endmodule

@@ src/xopc_queue.sv @@
// Two-entry command queue between front and back.
// Depends on xopc_pkg.
module xopc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  xopc_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output xopc_pkg::cmd_t rd_data_o
);
  import xopc_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

@@ src/xopc_back.sv @@
// Back end: saturating counter bank, read and clear, output register.
// Depends on xopc_pkg.
module xopc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  xopc_pkg::cmd_t         cmd_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [4:0]             counter_index_o,
  output logic [xopc_pkg::CounterBits-1:0] counter_value_o
);
  import xopc_pkg::*;

  logic [CounterBits-1:0] cnt_q [NumCounters];
  logic                   ov_q;
  logic [4:0]             oi_q;
  logic [CounterBits-1:0] ovl_q;
  logic                   take;

  assign cmd_ready_o = !ov_q || out_ready_i;
  assign take = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = ov_q;
  assign counter_index_o = oi_q;
  assign counter_value_o = ovl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumCounters; k++) cnt_q[k] <= '0;
      ov_q <= 1'b0;
    end else begin
      // Load a new result, or drop the held one once it is taken.
      if (take && cmd_i.cmd == CMD_READ) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (take) begin
        case (cmd_i.cmd)
          CMD_CLEAR: for (int k = 0; k < NumCounters; k++) cnt_q[k] <= '0;
          CMD_READ:  ;
          default: begin
            for (int k = 0; k < NumCounters; k++) begin
              if (((cmd_i.tot && k == int'(C_BYTES)) ||
                   (cmd_i.hit && k == int'(cmd_i.idx))) && !(&cnt_q[k]))
                cnt_q[k] <= cnt_q[k] + 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.cmd == CMD_READ) begin
      oi_q  <= cmd_i.idx;
      ovl_q <= (cmd_i.idx < CntIdxBits'(NumCounters)) ? cnt_q[cmd_i.idx] : '0;
    end
  end
endmodule

@@ src/x86_opcode_pattern_counter_core.sv @@
// Top level of the x86 opcode pattern counter: front classifier, command
// queue and counter back end. Depends on xopc_pkg and the xopc_* modules.
//
//  channel | direction | signals
//  in      | input     | in_valid_i/in_ready_o, opcode_i, code_byte_i,
//          |           | section_end_i, counter_select_i
//  out     | output    | out_valid_o/out_ready_i, counter_index_o, counter_value_o
//
// A code byte with the section-end flag starts a flush in which the single
// classifier walks the buffered bytes (up to 10) one position at a time.
// The back end applies one command per cycle from a two-entry queue, and a
// read result waits in the output register, stalling the queue only while
// it is not taken. Reset clears window, skip, flush and all counters at
// once.
module x86_opcode_pattern_counter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  code_byte_i,
  input  logic        section_end_i,
  input  logic [4:0]  counter_select_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  counter_index_o,
  output logic [47:0] counter_value_o
);
  import xopc_pkg::*;

  cmd_t f_cmd, b_cmd;
  logic f_valid, f_ready, b_valid, b_ready;

  // Classify and window incoming bytes.
  xopc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .code_byte_i,
    .section_end_i, .counter_select_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  // Decouple classification from counting.
  xopc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_cmd)
  );

  // Count, read and clear.
  xopc_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .out_valid_o, .out_ready_i, .counter_index_o, .counter_value_o
  );

  // A stalled result must hold its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(counter_value_o))
    else $error("result changed while stalled");

  // Input is never taken while the front cannot push into the queue.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> f_ready)
    else $error("input accepted with queue full");

  // A command the back end does not take stays valid in the queue.
  a_queue_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid && !b_ready |=> b_valid)
    else $error("queue lost a command");
endmodule

@@ sim/tb.sv @@
// Testbench for x86_opcode_pattern_counter_core: random code sections, reads
// and clears, checked against an in-bench opcode pattern predictor.
// Depends on xopc_pkg and the core RTL.
module tb;
  import xopc_pkg::*;

  // Predictor of counter readbacks; holds its own window, skip and counters.
  class count_board;
    logic [7:0]  win[WindowBytes];
    int unsigned fill;
    int unsigned skip;
    logic [47:0] cnt[NumCounters];
    logic [4:0]  exp_idx[$];
    logic [47:0] exp_val[$];
    int          errors;

    function new();
      foreach (win[i]) win[i] = 8'h00;
      foreach (cnt[i]) cnt[i] = '0;
      fill = 0; skip = 0; errors = 0;
    endfunction

    function void bump(int c);
      if (cnt[c] != {48{1'b1}}) cnt[c] = cnt[c] + 1;
    endfunction

    function automatic bit zero_run(int unsigned at, int unsigned n);
      for (int k = 0; k < n; k++) if (win[at + k] != 8'h00) return 0;
      return 1;
    endfunction

    function automatic bit rex(logic [7:0] b);
      return b >= 8'h40 && b <= 8'h4F;
    endfunction

    function automatic bit self_reg(logic [7:0] m);
      return m[7:6] == 2'b11 && m[5:3] == m[2:0];
    endfunction

    // Test position at with m bytes visible; return the skip count.
    function automatic int unsigned match_at(int unsigned at, int unsigned m);
      logic [7:0] b0, b1, b2, op, mr;
      int unsigned j, len, disp;
      b0 = win[at];
      b1 = m > 1 ? win[at+1] : 8'h00;
      b2 = m > 2 ? win[at+2] : 8'h00;
      if (m > 3 && b0 == 8'h55 && b1 == 8'h48 && b2 == 8'h89 && win[at+3] == 8'hE5) begin
        bump(C_PROLOGUE); return 3;
      end
      if (b0 == 8'h0F && m > 1 && b1 == 8'h05) begin bump(C_SYSCALL); return 1; end
      if (b0 == 8'hC9) begin bump(C_LEAVE); return 0; end
      if (m > 3 && b0 == 8'h48 && b1 == 8'h83 && b2 == 8'hEC) begin bump(C_SSUB); return 3; end
      if (m > 6 && b0 == 8'h48 && b1 == 8'h81 && b2 == 8'hEC) begin bump(C_SSUB); return 6; end
      if (m > 3 && b0 == 8'h48 && b1 == 8'h83 && b2 == 8'hC4) begin bump(C_SADD); return 3; end
      if (m > 6 && b0 == 8'h48 && b1 == 8'h81 && b2 == 8'hC4) begin bump(C_SADD); return 6; end
      if (b0 == 8'hFF && m > 1 && b1[5:3] == 3'd2) begin bump(C_ICALL); return 1; end
      if (b0 == 8'h8D) begin bump(C_LEA); return 0; end
      if (rex(b0) && m > 1 && b1 == 8'h8D) begin bump(C_LEA); return 1; end
      if ((b0 == 8'h31 || b0 == 8'h33) && m > 1 && self_reg(b1)) begin
        bump(C_XORZ); return 1;
      end
      if (rex(b0) && m > 2 && (b1 == 8'h31 || b1 == 8'h33) && self_reg(b2)) begin
        bump(C_XORZ); return 2;
      end
      if (b0 >= 8'hB8 && b0 <= 8'hBF && m > 4 && zero_run(at + 1, 4)) begin
        bump(C_MOVZ); return 4;
      end
      if (rex(b0) && m > 1 && b1 >= 8'hB8 && b1 <= 8'hBF) begin
        len = b0[3] ? 8 : 4;
        if (1 + len < m && zero_run(at + 2, len)) begin bump(C_MOVZ); return 1 + len; end
      end
      j = rex(b0) ? 1 : 0;
      if (j < m) begin
        op = win[at+j];
        if ((op == 8'h8A || op == 8'h8B || op == 8'h88 || op == 8'h89) && j + 2 < m) begin
          mr = win[at+j+1];
          if (mr[7:6] != 2'd3 && mr[2:0] == 3'd4 && win[at+j+2][2:0] == 3'd4) begin
            disp = mr[7:6] == 2'd1 ? 1 : (mr[7:6] == 2'd2 ? 4 : 0);
            bump((op == 8'h8A || op == 8'h8B) ? C_SLOAD : C_SSTORE);
            return j + 2 + disp;
          end
        end
      end
      if (b0 == 8'h41 && m > 1) begin
        if (b1 >= 8'h50 && b1 <= 8'h57) begin bump(C_PUSH); return 1; end
        if (b1 >= 8'h58 && b1 <= 8'h5F) begin bump(C_POP); return 1; end
      end
      if (b0 >= 8'h48 && b0 <= 8'h4F && m > 1 && b1 == 8'h63) begin bump(C_MOVSXD); return 1; end
      if (rex(b0) && m > 2 && b1 == 8'h0F && b2[7:4] == 4'h9) begin bump(C_SETCC); return 2; end
      if (b0 == 8'h0F && m > 1 && b1[7:4] == 4'h9) begin bump(C_SETCC); return 1; end
      if (b0 == 8'h0F && m > 1 && b1[7:4] == 4'h8) begin bump(C_JCC); return m > 5 ? 5 : 0; end
      if (b0 >= 8'h70 && b0 <= 8'h7F) begin bump(C_JCC); return m > 1 ? 1 : 0; end
      if (b0 == 8'hE8) begin bump(C_CALL); return m > 4 ? 4 : 0; end
      if (b0 == 8'hE9) begin bump(C_JMP); return m > 4 ? 4 : 0; end
      if (b0 == 8'hEB) begin bump(C_JMP); return m > 1 ? 1 : 0; end
      if (b0 == 8'hC3) begin bump(C_RET); return 0; end
      if (b0 == 8'hC2) begin bump(C_RET); return m > 2 ? 2 : 0; end
      if (b0 >= 8'h50 && b0 <= 8'h57) begin bump(C_PUSH); return 0; end
      if (b0 >= 8'h58 && b0 <= 8'h5F) begin bump(C_POP); return 0; end
      if (b0 == 8'h63) begin bump(C_MOVSXD); return 0; end
      return 0;
    endfunction

    function void visit(int unsigned at, int unsigned m);
      if (skip > 0) skip--;
      else skip = match_at(at, m);
    endfunction

    // Note one accepted input transfer.
    function void note_input(op_e op, logic [7:0] b, logic last, logic [4:0] sel);
      case (op)
        OP_READ: begin
          exp_idx.push_back(sel);
          exp_val.push_back(sel < NumCounters ? cnt[sel] : 48'd0);
        end
        OP_CLEAR: foreach (cnt[i]) cnt[i] = '0;
        OP_BYTE: begin
          bump(C_BYTES);
          if (fill < WindowBytes) begin win[fill] = b; fill++; end
          if (last) begin
            for (int unsigned p = 0; p < fill; p++) visit(p, fill - p);
            foreach (win[i]) win[i] = 8'h00;
            fill = 0; skip = 0;
          end else if (fill >= WindowBytes) begin
            visit(0, fill);
            for (int i = 0; i < WindowBytes - 1; i++) win[i] = win[i+1];
            win[WindowBytes-1] = 8'h00;
            fill--;
          end
        end
        default: ;
      endcase
    endfunction

    // Check one accepted result against the oldest expectation.
    function void check_result(logic [4:0] idx, logic [47:0] val);
      logic [4:0]  ei;
      logic [47:0] ev;
      if (exp_idx.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected readback idx=%0d val=%0d", idx, val);
        return;
      end
      ei = exp_idx.pop_front();
      ev = exp_val.pop_front();
      if (idx !== ei || val !== ev) begin
        errors++;
        if (errors <= 10)
          $display("readback mismatch: exp idx=%0d val=%0d, got idx=%0d val=%0d",
                   ei, ev, idx, val);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = OP_NONE;
  logic [7:0]  code_byte_i = 8'h00;
  logic        section_end_i = 1'b0;
  logic [4:0]  counter_select_i = 5'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [4:0]  counter_index_o;
  logic [47:0] counter_value_o;

  count_board  board = new();
  int unsigned cycles = 0;
  bit          quiet_out = 0;

  x86_opcode_pattern_counter_core dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones, and whole stretches without any.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Hold one transfer on the input channel until it is taken; valid stays
  // high into the next transfer when there is no gap.
  task automatic send(op_e op, logic [7:0] b, logic last, logic [4:0] sel, bit dense);
    int unsigned g;
    g = dense ? 0 : gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    code_byte_i      <= b;
    section_end_i    <= last;
    counter_select_i <= sel;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(op, b, last, sel);
  endtask

  task automatic send_section(logic [7:0] bytes[$], bit dense);
    foreach (bytes[i]) send(OP_BYTE, bytes[i], i == bytes.size() - 1, 5'($urandom), dense);
  endtask

  task automatic read_all(bit dense);
    for (int c = 0; c < NumCounters; c++) send(OP_READ, 8'($urandom), 1'b0, 5'(c), dense);
  endtask

  // Output side: random stalls, sample at the rising edge.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_result(counter_index_o, counter_value_o);
    out_ready_i <= quiet_out ? 1'b1 : ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Pick a pattern-shaped instruction with random fill-in bytes.
  function automatic void add_insn(ref logic [7:0] q[$]);
    logic [7:0] r;
    r = 8'($urandom);
    case ($urandom_range(0, 22))
      0: q = {q, 8'h55, 8'h48, 8'h89, 8'hE5};
      1: q = {q, 8'h0F, 8'h05};
      2: q = {q, 8'hC9};
      3: q = {q, 8'h48, 8'h83, ($urandom_range(0, 1) ? 8'hEC : 8'hC4), r};
      4: q = {q, 8'h48, 8'h81, ($urandom_range(0, 1) ? 8'hEC : 8'hC4), r, 8'h00, 8'h01, 8'h00};
      5: q = {q, 8'hFF, {r[7:6], 3'd2, r[2:0]}};
      6: q = {q, (r[0] ? 8'h48 : 8'h8D), 8'h8D, r};
      7: q = {q, 8'h31 | {6'd0, r[1], 1'b0}, {2'b11, r[5:3], r[5:3]}};
      8: q = {q, 8'h40 | {4'd0, r[3:0]}, 8'h31, {2'b11, r[5:3], r[5:3]}};
      9: q = {q, 8'hB8 | {5'd0, r[2:0]}, 8'h00, 8'h00, 8'h00, 8'h00};
      10: begin
        q = {q, 8'h40 | {4'd0, r[3:0]}, 8'hB8 | {5'd0, r[6:4]}};
        repeat (r[3] ? 8 : 4) q.push_back(8'h00);
      end
      11: q = {q, 8'h48, (r[0] ? 8'h8B : 8'h89), {r[7:6] == 2'd3 ? 2'd1 : r[7:6], r[5:3], 3'd4},
               8'h24, r};
      12: q = {q, 8'h41, 8'h50 | {4'd0, r[3:0]}};
      13: q = {q, 8'h48 | {5'd0, r[2:0]}, 8'h63, r};
      14: q = {q, 8'h0F, 8'h90 | {4'd0, r[3:0]}, 8'hC0};
      15: q = {q, 8'h0F, 8'h80 | {4'd0, r[3:0]}, r, 8'h00, 8'h00, 8'h00};
      16: q = {q, 8'h70 | {4'd0, r[3:0]}, r};
      17: q = {q, (r[0] ? 8'hE8 : 8'hE9), r, 8'h00, 8'h00, 8'h00};
      18: q = {q, 8'hEB, r, (r[1] ? 8'hC3 : 8'hC2)};
      19: q = {q, 8'h50 | {4'd0, r[3:0]}};
      20: q = {q, 8'h63, 8'h4C, 8'h0F, 8'h9F};
      default: q = {q, r};
    endcase
  endfunction

  initial begin
    logic [7:0] sec[$];
    int unsigned sent;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: prologue, stack ops, boundary-cut sequences, extremes.
    send_section('{8'h55, 8'h48, 8'h89, 8'hE5, 8'h48, 8'h83, 8'hEC, 8'h20, 8'h48,
                   8'h89, 8'h44, 8'h24, 8'h08, 8'hC9, 8'hC3}, 1);
    send_section('{8'h0F, 8'h85}, 0);             // jcc cut by section end
    send_section('{8'hE8, 8'h00}, 0);             // call cut by section end before its displacement
    send_section('{8'hFF}, 0);
    send(OP_NONE, 8'hFF, 1'b1, 5'd31, 0);         // unused opcode does nothing
    send(OP_READ, 8'h00, 1'b0, 5'd31, 0);         // select out of range
    send(OP_READ, 8'hFF, 1'b1, 5'd20, 0);
    send(OP_READ, 8'h00, 1'b0, 5'd0, 0);
    send_section('{8'h48, 8'hB8, 8'h00, 8'h00, 8'h00, 8'h00}, 0);
    send(OP_BYTE, 8'h00, 1'b0, 5'd0, 0);          // open section across a clear
    send(OP_CLEAR, 8'h00, 1'b0, 5'd0, 0);
    send(OP_BYTE, 8'h05, 1'b1, 5'd0, 0);

    // Random sections of mostly well-formed instructions, with reads and clears.
    sent = 0;
    while (sent < 650) begin
      sec.delete();
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 12)) sec.push_back(8'($urandom));
      else
        repeat ($urandom_range(1, 8)) add_insn(sec);
      send_section(sec, $urandom_range(0, 3) == 0);
      sent += sec.size();
      case ($urandom_range(0, 9))
        0: send(OP_CLEAR, 8'($urandom), 1'($urandom), 5'($urandom), 0);
        1: send(OP_NONE, 8'($urandom), 1'($urandom), 5'($urandom), 0);
        2, 3: send(OP_READ, 8'($urandom), 1'($urandom), 5'($urandom), 0);
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        read_all($urandom_range(0, 1));
        sent += NumCounters;
      end
    end
    read_all(0);
    in_valid_i <= 1'b0;

    // Drain, then let the back end settle.
    quiet_out = 1;
    while (board.exp_idx.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/xopc_pkg.sv
src/xopc_front.sv
src/xopc_queue.sv
src/xopc_back.sv
src/x86_opcode_pattern_counter_core.sv
sim/tb.sv
